// ===== rtl/klst_pkg.sv =====
package klst_pkg;

   // Table geometry
   localparam int SLOT_COUNT = 32;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   // Result codes for how_chosen
   localparam logic [1:0] HOW_KEY    = 2'd0;
   localparam logic [1:0] HOW_EXPIRE = 2'd1;
   localparam logic [1:0] HOW_FORCE  = 2'd2;

   // Operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY,
      ST_COUNT
   } state_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      logic        eval;      // capture match flags and decay product
      logic        apply;     // write allocation or apply decay
      logic        is_tick;
      logic        use_key;   // allocation goes to first key match
      logic        to_zero;   // allocation goes to slot zero
      logic [15:0] key;
      logic [15:0] radius;
      logic [15:0] decay;
      logic [15:0] elapsed;
      logic [31:0] now;
      logic [31:0] expiry;    // saturated now + lifetime
   } ctl_type;

   // Priority chain passed from one cell to the next
   typedef struct packed {
      logic key_seen;
      logic exp_seen;
   } chain_type;

   // Per-cell status back to the sequencer
   typedef struct packed {
      logic take;
      logic live;
   } stat_type;

   // Saturating 32-bit add
   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ===== rtl/keyed_light_slot_table_core.sv =====
// Light slot table: a row of SLOT_COUNT cells, each holding one slot's key,
// expiry, radius and decay rate. Every item (allocate or tick) passes through
// the steps accept, evaluate (each cell compares its key and expiry and forms
// its elapsed*decay product in its own multiplier), apply (the priority chain
// through the row picks the slot, or every live cell decays), and count (the
// live flags of all cells are summed into the result). The next item is taken
// once the result has been registered; a result that waits on rsp_ready holds
// the table in the count step. Reset clears every slot at once, no sweep.
module keyed_light_slot_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [15:0] req_light_key,
   input  logic [15:0] req_start_radius,
   input  logic [15:0] req_lifetime,
   input  logic [15:0] req_decay_rate,
   input  logic [15:0] req_elapsed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_slot,
   output logic [1:0]  rsp_how_chosen,
   output logic [5:0]  rsp_live_count
);
   import klst_pkg::*;

   state_type   state_ff, state_in;

   // Captured item
   logic        op_ff;
   logic [15:0] key_ff, radius_ff, life_ff, decay_ff, elapsed_ff;
   logic        op_in;
   logic [15:0] key_in, radius_in, life_in, decay_in, elapsed_in;

   logic [31:0] now_ff, now_in;
   logic [SLOT_W-1:0] chosen_ff, chosen_in;
   logic [1:0]  how_ff, how_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_slot_ff, rsp_slot_in;
   logic [1:0]  rsp_how_ff, rsp_how_in;
   logic [5:0]  rsp_cnt_ff, rsp_cnt_in;

   ctl_type     ctl;
   chain_type   chain [SLOT_COUNT+1];
   stat_type    stat  [SLOT_COUNT];

   logic [SLOT_W-1:0]  take_idx;
   logic [CNT_W-1:0]   live_cnt;
   logic [SLOT_W+4:0]  slot_ext;
   logic [CNT_W+5:0]   cnt_ext;
   logic               accept;
   logic               key_nz;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign key_nz    = (key_ff != 16'd0);

   // Broadcast to the cells
   always_comb begin
      ctl.eval    = (state_ff == ST_EVAL);
      ctl.apply   = (state_ff == ST_APPLY);
      ctl.is_tick = (op_ff == OP_TICK);
      ctl.use_key = key_nz && chain[SLOT_COUNT].key_seen;
      ctl.to_zero = ~ctl.use_key && ~chain[SLOT_COUNT].exp_seen;
      ctl.key     = key_ff;
      ctl.radius  = radius_ff;
      ctl.decay   = decay_ff;
      ctl.elapsed = elapsed_ff;
      ctl.now     = now_ff;
      ctl.expiry  = sat_add32(now_ff, {16'd0, life_ff});
   end

   assign chain[0] = '0;

   // Row of slot cells
   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      klst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .force_here (i == 0),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .stat       (stat[i])
      );
   end

   // Index of the taking cell (at most one)
   always_comb begin
      take_idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (stat[i].take) begin
            take_idx = take_idx | SLOT_W'(i);
         end
      end
   end

   // Live count over the row
   always_comb begin
      live_cnt = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         live_cnt = live_cnt + CNT_W'(stat[i].live);
      end
   end

   assign slot_ext = {5'd0, chosen_ff};
   assign cnt_ext  = {6'd0, live_cnt};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      radius_in    = radius_ff;
      life_in      = life_ff;
      decay_in     = decay_ff;
      elapsed_in   = elapsed_ff;
      now_in       = now_ff;
      chosen_in    = chosen_ff;
      how_in       = how_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_how_in   = rsp_how_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_operation;
               key_in     = req_light_key;
               radius_in  = req_start_radius;
               life_in    = req_lifetime;
               decay_in   = req_decay_rate;
               elapsed_in = req_elapsed;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // cells compare against the old time; the tick advances it here
            if (op_ff == OP_TICK) begin
               now_in = sat_add32(now_ff, {16'd0, elapsed_ff});
            end
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (op_ff == OP_TICK) begin
               chosen_in = '0;
               how_in    = HOW_KEY;
            end else begin
               chosen_in = take_idx;
               if (ctl.use_key) begin
                  how_in = HOW_KEY;
               end else if (ctl.to_zero) begin
                  how_in = HOW_FORCE;
               end else begin
                  how_in = HOW_EXPIRE;
               end
            end
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = slot_ext[4:0];
               rsp_how_in   = how_ff;
               rsp_cnt_in   = (cnt_ext > (CNT_W+6)'(63)) ? 6'd63 : cnt_ext[5:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      radius_ff   <= radius_in;
      life_ff     <= life_in;
      decay_ff    <= decay_in;
      elapsed_ff  <= elapsed_in;
      chosen_ff   <= chosen_in;
      how_ff      <= how_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_how_ff  <= rsp_how_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_how_chosen = rsp_how_ff;
   assign rsp_live_count = rsp_cnt_ff;

endmodule

// ===== rtl/klst_cell.sv =====
module klst_cell (
   input  logic                clock,
   input  logic                reset,
   input  klst_pkg::ctl_type   ctl,
   input  logic                force_here,
   input  klst_pkg::chain_type chain_in,
   output klst_pkg::chain_type chain_out,
   output klst_pkg::stat_type  stat
);
   import klst_pkg::*;

   // Slot state
   logic [15:0] key_ff,    key_in;
   logic [31:0] expiry_ff, expiry_in;
   logic [15:0] radius_ff, radius_in;
   logic [15:0] decay_ff,  decay_in;

   // Per-item scratch
   logic        hit_ff,    hit_in;
   logic        expired_ff, expired_in;
   logic [31:0] loss_ff,   loss_in;

   logic        take;
   logic        live;
   logic [21:0] loss;

   // Priority chain: first matching cell wins
   assign chain_out.key_seen = chain_in.key_seen | hit_ff;
   assign chain_out.exp_seen = chain_in.exp_seen | expired_ff;

   always_comb begin
      if (ctl.use_key) begin
         take = hit_ff & ~chain_in.key_seen;
      end else if (ctl.to_zero) begin
         take = force_here;
      end else begin
         take = expired_ff & ~chain_in.exp_seen;
      end
   end

   assign live      = (expiry_ff >= ctl.now) && (radius_ff != 16'd0);
   assign stat.take = take;
   assign stat.live = live;
   assign loss      = loss_ff[31:10];

   // Next state
   always_comb begin
      key_in     = key_ff;
      expiry_in  = expiry_ff;
      radius_in  = radius_ff;
      decay_in   = decay_ff;
      hit_in     = hit_ff;
      expired_in = expired_ff;
      loss_in    = loss_ff;
      if (ctl.eval) begin
         hit_in     = (key_ff == ctl.key);
         expired_in = (expiry_ff < ctl.now);
         loss_in    = {16'd0, ctl.elapsed} * {16'd0, decay_ff};
      end
      if (ctl.apply) begin
         if (ctl.is_tick) begin
            if (live) begin
               if (loss >= {6'd0, radius_ff}) begin
                  radius_in = 16'd0;
               end else begin
                  radius_in = radius_ff - loss[15:0];
               end
            end
         end else if (take) begin
            key_in    = ctl.key;
            expiry_in = ctl.expiry;
            radius_in = ctl.radius;
            decay_in  = ctl.decay;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         expiry_ff  <= '0;
         radius_ff  <= '0;
         decay_ff   <= '0;
         hit_ff     <= 1'b0;
         expired_ff <= 1'b0;
      end else begin
         key_ff     <= key_in;
         expiry_ff  <= expiry_in;
         radius_ff  <= radius_in;
         decay_ff   <= decay_in;
         hit_ff     <= hit_in;
         expired_ff <= expired_in;
      end
   end

   // Product scratch needs no reset
   always_ff @(posedge clock) begin
      loss_ff <= loss_in;
   end

endmodule
